// File: rtl/itaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, constants and the digit glyph function of the formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int BIN_W              = 64;
    localparam int DIGIT_W            = 4;
    localparam int STORE_DEPTH        = 20;
    localparam int COUNT_W            = 5;
    localparam int STEP_CNT_W         = 6;
    localparam int PAD_W              = 5;
    localparam int CHAR_W             = 7;
    localparam int DEC_DIGITS_DEFAULT = 20;
    localparam int HEX_DIGITS_DEFAULT = 16;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP   = STEP_CNT_W'(BIN_W - 1);
    localparam logic [CHAR_W-1:0]     CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]     CHAR_LETTER = 7'h37;
    localparam logic [DIGIT_W-1:0]    DIGIT_TEN   = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic dab_step;
        logic trim_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip_conv;
        logic conv_done;
        logic trim_done;
        logic last_digit;
        logic out_free;
    } ctrl_stat_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN)
            return CHAR_ZERO + ext;
        else
            return CHAR_LETTER + ext;
    endfunction

endpackage

// File: rtl/itaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: accept, decimal conversion steps, leading-zero trim, emission.
// ----------------------------------------------------------------------------
module itaf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  itaf_pkg::ctrl_stat_t stat,
    output itaf_pkg::ctrl_cmd_t  cmd
);

    itaf_pkg::state_t state_reg;
    itaf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itaf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = stat.skip_conv ? itaf_pkg::ST_TRIM : itaf_pkg::ST_CONV;
            end
            itaf_pkg::ST_CONV:
            begin
                if (stat.conv_done)
                    state_next = itaf_pkg::ST_TRIM;
            end
            itaf_pkg::ST_TRIM:
            begin
                if (stat.trim_done)
                    state_next = itaf_pkg::ST_EMIT;
            end
            itaf_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.last_digit)
                    state_next = itaf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = itaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            itaf_pkg::ST_CONV:
            begin
                cmd.dab_step = 1'b1;
            end
            itaf_pkg::ST_TRIM:
            begin
                cmd.trim_step = !stat.trim_done;
            end
            itaf_pkg::ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/itaf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_datapath
// Digit register, shift-add-3 converter, digit count and output register.
// ----------------------------------------------------------------------------
module itaf_datapath #(
    parameter int MaxDecDigits = itaf_pkg::DEC_DIGITS_DEFAULT,
    parameter int MaxHexDigits = itaf_pkg::HEX_DIGITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_hex,
    input  logic [itaf_pkg::BIN_W-1:0]   in_value,
    input  logic [itaf_pkg::PAD_W-1:0]   in_pad,
    input  itaf_pkg::ctrl_cmd_t          cmd,
    output itaf_pkg::ctrl_stat_t         stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [itaf_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last
);

    localparam int Depth  = itaf_pkg::STORE_DEPTH;
    localparam int DW     = itaf_pkg::DIGIT_W;
    localparam int BW     = itaf_pkg::BIN_W;
    localparam int CW     = itaf_pkg::COUNT_W;
    localparam int DecLim = (MaxDecDigits < Depth) ? MaxDecDigits : Depth;
    localparam int HexLim = (MaxHexDigits < Depth) ? MaxHexDigits : Depth;
    localparam logic [BW-1:0] HexKeep =
        (HexLim * DW >= BW) ? {BW{1'b1}} : ((BW'(1) << (HexLim * DW)) - BW'(1));
    localparam logic [Depth*DW-1:0] DecKeep =
        (DecLim >= Depth) ? {(Depth*DW){1'b1}}
                          : (((Depth*DW)'(1) << (DecLim * DW)) - (Depth*DW)'(1));
    localparam logic [CW-1:0] HexLimC = CW'(HexLim);
    localparam logic [CW-1:0] DecLimC = CW'(DecLim);
    localparam logic [CW-1:0] One     = CW'(1);

    logic [Depth-1:0][DW-1:0]          digits_reg, digits_next;
    logic [BW-1:0]                     bin_reg, bin_next;
    logic [itaf_pkg::STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]                     ndig_reg, ndig_next;
    logic [CW-1:0]                     pad_reg, pad_next;
    logic                              hex_reg, hex_next;
    logic                              zero_reg, zero_next;
    logic                              hex_high_reg, hex_high_next;
    logic                              valid_reg, valid_next;
    logic [itaf_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic                              last_reg, last_next;

    logic [Depth-1:0][DW-1:0]          adj;
    logic [Depth*DW+BW-1:0]            cat;
    logic [DW-1:0]                     top_digit;
    logic                              dec_high;
    logic                              high;
    logic [CW-1:0]                     floor_cnt;
    logic [CW-1:0]                     idx;
    logic [CW-1:0]                     pad_sat;
    logic                              in_zero;

    always_comb
    begin
        for (int i = 0; i < Depth; i++)
            adj[i] = (digits_reg[i] >= DW'(5)) ? digits_reg[i] + DW'(3) : digits_reg[i];
    end

    assign cat       = {adj, bin_reg} << 1;
    assign idx       = ndig_reg - One;
    assign top_digit = digits_reg[idx];
    assign dec_high  = |(digits_reg & ~DecKeep);
    assign high      = hex_reg ? hex_high_reg : dec_high;
    assign in_zero   = (in_value == '0);
    assign pad_sat   = (in_pad > HexLimC) ? HexLimC : in_pad;

    always_comb
    begin
        priority if (zero_reg)
            floor_cnt = One;
        else if (high)
            floor_cnt = hex_reg ? HexLimC : DecLimC;
        else if (hex_reg && (pad_reg != '0))
            floor_cnt = pad_reg;
        else
            floor_cnt = One;
    end

    assign stat.skip_conv  = in_hex || in_zero;
    assign stat.conv_done  = (cnt_reg == itaf_pkg::LAST_STEP);
    assign stat.trim_done  = (ndig_reg <= floor_cnt) || (top_digit != '0);
    assign stat.last_digit = (ndig_reg == One);
    assign stat.out_free   = !valid_reg || out_ready;

    always_comb
    begin
        digits_next   = digits_reg;
        bin_next      = bin_reg;
        cnt_next      = cnt_reg;
        ndig_next     = ndig_reg;
        pad_next      = pad_reg;
        hex_next      = hex_reg;
        zero_next     = zero_reg;
        hex_high_next = hex_high_reg;
        valid_next    = valid_reg && !out_ready;
        char_next     = char_reg;
        last_next     = last_reg;
        if (cmd.load)
        begin
            digits_next   = in_hex ? (Depth*DW)'(in_value) : '0;
            bin_next      = in_value;
            cnt_next      = '0;
            ndig_next     = in_hex ? HexLimC : DecLimC;
            pad_next      = pad_sat;
            hex_next      = in_hex;
            zero_next     = in_zero;
            hex_high_next = |(in_value & ~HexKeep);
        end
        if (cmd.dab_step)
        begin
            digits_next = cat[Depth*DW+BW-1:BW];
            bin_next    = cat[BW-1:0];
            cnt_next    = cnt_reg + itaf_pkg::STEP_CNT_W'(1);
        end
        if (cmd.trim_step)
            ndig_next = ndig_reg - One;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
            char_next  = itaf_pkg::glyph(top_digit);
            last_next  = (ndig_reg == One);
            ndig_next  = ndig_reg - One;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ndig_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            ndig_reg  <= ndig_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        bin_reg      <= bin_next;
        pad_reg      <= pad_next;
        hex_reg      <= hex_next;
        zero_reg     <= zero_next;
        hex_high_reg <= hex_high_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// File: rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Sequence: hex loads the digits directly, then trims leading zeros; decimal
//   loads, runs shift-add-3 steps (skipped for zero), trims, then the first beat.
// Throughput: one character beat per cycle once emission starts, while m_tready
//   is high; one item at a time, a new one once the last beat has been loaded.
// Reset: rst_n clears the sequencer, digit count and output valid at once.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
    parameter int MAX_DEC_DIGITS = itaf_pkg::DEC_DIGITS_DEFAULT,
    parameter int MAX_HEX_DIGITS = itaf_pkg::HEX_DIGITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value[63:0], pad_width[68:64], zero fill
    input  logic [0:0]  s_tuser,   // action (radix select)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code[6:0], zero fill
    output logic        m_tlast
);

    itaf_pkg::ctrl_cmd_t           cmd;
    itaf_pkg::ctrl_stat_t          stat;
    logic [itaf_pkg::CHAR_W-1:0]   out_char;

    itaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itaf_datapath #(
        .MaxDecDigits (MAX_DEC_DIGITS),
        .MaxHexDigits (MAX_HEX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_hex    (s_tuser[0]),
        .in_value  (s_tdata[itaf_pkg::BIN_W-1:0]),
        .in_pad    (s_tdata[itaf_pkg::BIN_W+itaf_pkg::PAD_W-1:itaf_pkg::BIN_W]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again before item finished");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("beat loaded over a pending beat");

    a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a number");

endmodule
